@@ hdl/rsm_pkg.sv @@
// Package for the random sample multiset: widths, command and status codes,
// controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

	localparam int DATA_W       = 32;
	localparam int KIND_W       = 2;
	localparam int STAT_W       = 2;
	localparam int CAPACITY_DEF = 64;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_REM_RD,
		S_REM_WR,
		S_DIV,
		S_SMP_WR,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

@@ hdl/rsm_req_if.sv @@
// Request channel of the random sample multiset.
// Depends on rsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rsm_req_if import rsm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;
	logic [DATA_W-1:0]        rand_word;

	modport source(output valid, kind, value, rand_word, input ready);
	modport sink(input valid, kind, value, rand_word, output ready);
endinterface
`default_nettype wire

@@ hdl/rsm_rsp_if.sv @@
// Response channel of the random sample multiset.
// Depends on rsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rsm_rsp_if import rsm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     answer;
	logic signed [DATA_W-1:0] sample_value;
	logic [STAT_W-1:0]        status;

	modport source(output valid, answer, sample_value, status, input ready);
	modport sink(input valid, answer, sample_value, status, output ready);
endinterface
`default_nettype wire

@@ hdl/rsm_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/rsm_divider.sv @@
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit a cycle.
// Depends on rsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsm_divider import rsm_pkg::*; #(
	parameter int VW = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [VW-1:0]     divisor,
	output logic                   done,
	output logic      [VW-1:0]     remainder
);

	localparam int SW = $clog2(DATA_W);

	logic              busy_q;
	logic [SW-1:0]     cnt_q;
	logic [DATA_W-1:0] dvd_q;
	logic [VW-1:0]     dvs_q;
	logic [VW-1:0]     rem_q;
	logic [VW:0]       trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SW'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
		end
	end

	assign remainder = rem_q;

endmodule
`default_nettype wire

@@ hdl/random_sample_multiset.sv @@
// Random sample multiset: request channel in, one response word per request out.
// Slot memory is rsm_ram, sampling index from rsm_divider; depends on rsm_pkg
// and the rsm_req_if / rsm_rsp_if interfaces.
//
// Usage: a request word carries kind (insert, remove, sample), value and rand_word.
// Each request yields exactly one response word (answer, sample_value, status).
// Requests are handled one at a time; req.ready is high only while the
// controller is idle. The response sits in an output register, so the next
// request is taken while a response still waits on rsp.ready.
// Flow, with n the element count at the start of the request:
//   insert: scans all n slots, then writes slot n (full store: no scan)
//   remove: scans all n slots; if found, copies the last slot over the hit
//   sample: reads slot rand_word mod n (empty store, other codes: no read)
// The scans read one slot per cycle through the single read port of the
// slot memory; sampling waits on the bit-serial remainder unit.
// Reset clears the element count and the controller; slot memory
// is not cleared, as only occupied slots are ever read. When the receiver
// stalls, a finished response holds in the output register and the
// controller waits in its response state until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module random_sample_multiset import rsm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rsm_req_if.sink    req,
	rsm_rsp_if.source  rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = DATA_W + AW;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     scan_idx_q;
	logic [CW-1:0]     copies_q;
	logic [AW-1:0]     max_rank_q;
	logic [AW-1:0]     hit_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [KIND_W-1:0] kind_q;
	logic [DATA_W-1:0] value_q;

	logic              res_ans_q;
	logic [DATA_W-1:0] res_smp_q;
	logic [STAT_W-1:0] res_stat_q;

	logic              rsp_vld_q;
	logic              rsp_ans_q;
	logic [DATA_W-1:0] rsp_smp_q;
	logic [STAT_W-1:0] rsp_stat_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [MW-1:0]     wdata;
	logic [AW-1:0]     raddr;
	logic [MW-1:0]     rdata;
	logic              issue;
	logic              scan_end;
	logic              accept;
	logic              full;
	logic              div_start;
	logic              div_done;
	logic [CW-1:0]     div_rem;
	logic              rsp_free;
	logic              rd_match;

	rsm_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	rsm_divider #(.VW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.rand_word),
		.divisor  (count_q),
		.done     (div_done),
		.remainder(div_rem)
	);

	assign accept   = req.valid && req.ready;
	assign full     = count_q == CW'(CAPACITY);
	assign issue    = (state_q == S_SCAN) && (scan_idx_q < count_q);
	assign scan_end = (state_q == S_SCAN) && (scan_idx_q == count_q) && !rd_vld_s1;
	assign rsp_free = !rsp_vld_q || rsp.ready;
	assign rd_match = rd_vld_s1 && (rdata[MW-1:AW] == value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		we        = 1'b0;
		waddr     = hit_q;
		wdata     = rdata;
		raddr     = scan_idx_q[AW-1:0];
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.kind)
						KIND_INSERT: state_d = full ? S_RESP : S_SCAN;
						KIND_REMOVE: state_d = S_SCAN;
						KIND_SAMPLE: begin
							if (count_q == '0) begin
								state_d = S_RESP;
							end else begin
								div_start = 1'b1;
								state_d   = S_DIV;
							end
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					if (kind_q == KIND_INSERT) begin
						we      = 1'b1;
						waddr   = count_q[AW-1:0];
						wdata   = {value_q, copies_q[AW-1:0]};
						state_d = S_RESP;
					end else begin
						state_d = (copies_q == '0) ? S_RESP : S_REM_RD;
					end
				end
			end
			S_REM_RD: begin
				raddr   = AW'(count_q - 1'b1);
				state_d = S_REM_WR;
			end
			S_REM_WR: begin
				we      = 1'b1;
				state_d = S_RESP;
			end
			S_DIV: begin
				if (div_done) begin
					raddr   = div_rem[AW-1:0];
					state_d = S_SMP_WR;
				end
			end
			S_SMP_WR: state_d = S_RESP;
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (scan_end && kind_q == KIND_INSERT) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == S_REM_WR) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == S_RESP && rsp_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[AW-1:0];
		if (issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (rd_match) begin
			copies_q <= copies_q + 1'b1;
			if (copies_q == '0 || rdata[AW-1:0] > max_rank_q) begin
				max_rank_q <= rdata[AW-1:0];
				hit_q      <= rd_idx_s1;
			end
		end
		if (accept) begin
			kind_q     <= req.kind;
			value_q    <= req.value;
			scan_idx_q <= '0;
			copies_q   <= '0;
			res_ans_q  <= 1'b0;
			res_smp_q  <= '0;
			if (req.kind == KIND_INSERT && full) begin
				res_stat_q <= STAT_FULL;
			end else if (req.kind == KIND_SAMPLE && count_q == '0) begin
				res_stat_q <= STAT_EMPTY;
			end else begin
				res_stat_q <= STAT_DONE;
			end
		end
		if (scan_end && kind_q == KIND_INSERT) begin
			res_ans_q <= copies_q == '0;
		end
		if (state_q == S_REM_WR) begin
			res_ans_q <= 1'b1;
		end
		if (state_q == S_SMP_WR) begin
			res_smp_q <= rdata[MW-1:AW];
		end
		if (state_q == S_RESP && rsp_free) begin
			rsp_ans_q  <= res_ans_q;
			rsp_smp_q  <= res_smp_q;
			rsp_stat_q <= res_stat_q;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.answer       = rsp_ans_q;
	assign rsp.sample_value = rsp_smp_q;
	assign rsp.status       = rsp_stat_q;

endmodule
`default_nettype wire

@@ hdl/rsm_checker.sv @@
// Port-level assertions for random_sample_multiset, attached by bind.
// Depends on rsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsm_checker import rsm_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              rsp_answer,
	input wire logic [DATA_W-1:0] rsp_sample_value,
	input wire logic [STAT_W-1:0] rsp_status
);

	// one request at a time: ready drops right after a word is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before taken");

	a_answer_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_answer |-> rsp_status == STAT_DONE)
		else $error("answer set with error status");

	a_sample_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_sample_value != '0 |-> rsp_status == STAT_DONE && !rsp_answer)
		else $error("sample value on non-sample response");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == STAT_DONE || rsp_status == STAT_FULL
			|| rsp_status == STAT_EMPTY)
		else $error("undefined status code");

endmodule

bind random_sample_multiset rsm_checker u_rsm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_answer      (rsp.answer),
	.rsp_sample_value(rsp.sample_value),
	.rsp_status      (rsp.status)
);
`default_nettype wire
